// File: hdl/xkbc_pkg.sv
package xkbc_pkg;

    typedef logic [63:0] t_word;
    typedef logic [7:0]  t_byte;
    typedef logic [2:0]  t_pos;
    typedef logic [31:0] t_half;

    localparam t_word MUL_CONST = 64'h2545_F491_4F6C_DD1D;
    localparam t_half MUL_LO    = MUL_CONST[31:0];
    localparam t_half MUL_HI    = MUL_CONST[63:32];

    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;

    // Cycles from a new word at the refresh unit input to its refreshed value.
    localparam logic [1:0] REFRESH_LATENCY = 2'd3;

    function automatic t_word xorshift(input t_word w);
        t_word a;
        t_word b;
        a = w ^ (w >> SHIFT_A);
        b = a ^ (a << SHIFT_B);
        return b ^ (b >> SHIFT_C);
    endfunction

endpackage

// File: hdl/xkbc_if.sv
interface xkbc_in_if;
    logic             valid;
    logic             ready;
    xkbc_pkg::t_byte  data_byte;
    logic             buffer_start;
    logic             buffer_end;

    modport source (output valid, output data_byte, output buffer_start, output buffer_end,
                     input ready);
    modport sink   (input valid, input data_byte, input buffer_start, input buffer_end,
                     output ready);
endinterface

interface xkbc_out_if;
    logic             valid;
    logic             ready;
    xkbc_pkg::t_byte  out_byte;
    logic             out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hdl/xkbc_refresh.sv
module xkbc_refresh (
    input  logic            i_clk,
    input  xkbc_pkg::t_word i_word,
    output xkbc_pkg::t_word o_word
);

    xkbc_pkg::t_word r_x;
    xkbc_pkg::t_word r_p_ll;
    xkbc_pkg::t_half r_p_hl;
    xkbc_pkg::t_half r_p_lh;
    xkbc_pkg::t_word r_word;

    xkbc_pkg::t_word n_p_ll;
    xkbc_pkg::t_half n_p_hl;
    xkbc_pkg::t_half n_p_lh;
    xkbc_pkg::t_half n_cross;

    // The product modulo 2^64 needs the full low partial product and only the
    // low halves of the two cross products.
    always_comb begin
        n_p_ll  = 64'(r_x[31:0]) * 64'(xkbc_pkg::MUL_LO);
        n_p_hl  = r_x[63:32] * xkbc_pkg::MUL_LO;
        n_p_lh  = r_x[31:0] * xkbc_pkg::MUL_HI;
        n_cross = r_p_hl + r_p_lh;
    end

    always_ff @(posedge i_clk) begin
        r_x    <= xkbc_pkg::xorshift(i_word);
        r_p_ll <= n_p_ll;
        r_p_hl <= n_p_hl;
        r_p_lh <= n_p_lh;
        r_word <= r_p_ll + {n_cross, 32'd0};
    end

    assign o_word = r_word;

endmodule

// File: hdl/xorshift_keystream_byte_cipher.sv
// Channel  Direction  Payload                               Transaction when
// i_in     in         data_byte, buffer_start, buffer_end   valid && ready
// o_out    out        out_byte, out_last                    valid && ready
// i_cfg    in         i_cfg_wr_data (cipher key)            i_cfg_wr_en
//
// One byte per cycle while no key settle runs; each result appears in the output
// register in the cycle after its input transaction, and the input stalls while that result waits untaken.
// Two refresh pipelines hold the refreshed key and the next group's
// word ready, so a group boundary or a buffer start does not stall the input.
// After reset and after each key write the input stays not ready
// while the refreshed key settles. Reset is synchronous and active low.
module xorshift_keystream_byte_cipher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xkbc_in_if.sink         i_in,
    xkbc_out_if.source      o_out,
    input  logic            i_cfg_wr_en,
    input  xkbc_pkg::t_word i_cfg_wr_data
);

    xkbc_pkg::t_word r_cipher_key;
    xkbc_pkg::t_word r_word;
    xkbc_pkg::t_pos  r_pos;
    logic [1:0]      r_settle;
    logic            r_out_valid;
    xkbc_pkg::t_byte r_out_byte;
    logic            r_out_last;

    xkbc_pkg::t_word key_word;
    xkbc_pkg::t_word next_word;
    xkbc_pkg::t_word n_word;
    xkbc_pkg::t_pos  pos_use;
    logic            in_accept;

    xkbc_refresh u_key_refresh (
        .i_clk  (i_clk),
        .i_word (r_cipher_key),
        .o_word (key_word)
    );

    xkbc_refresh u_word_refresh (
        .i_clk  (i_clk),
        .i_word (r_word),
        .o_word (next_word)
    );

    assign i_in.ready = (r_settle == 2'd0) && (!r_out_valid || o_out.ready);
    assign in_accept  = i_in.valid && i_in.ready;

    always_comb begin
        pos_use = i_in.buffer_start ? xkbc_pkg::t_pos'(0) : r_pos;
        priority if (i_in.buffer_start) begin
            n_word = key_word;
        end else if (r_pos == xkbc_pkg::t_pos'(0)) begin
            n_word = next_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
            r_word       <= '0;
            r_pos        <= '0;
            r_settle     <= xkbc_pkg::REFRESH_LATENCY;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cipher_key <= i_cfg_wr_data;
                r_settle     <= xkbc_pkg::REFRESH_LATENCY;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            if (in_accept) begin
                r_word      <= n_word;
                r_pos       <= pos_use + xkbc_pkg::t_pos'(1);
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte <= i_in.data_byte ^ n_word[{pos_use, 3'b000} +: 8];
            r_out_last <= i_in.buffer_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

    a_cfg_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !i_in.ready)
        else $error("input ready while refreshed key settles");

    a_start_restarts_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.buffer_start) |=> (r_pos == xkbc_pkg::t_pos'(1)))
        else $error("buffer start did not restart the byte position");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in.buffer_start)
            |=> (r_pos == $past(r_pos) + xkbc_pkg::t_pos'(1)))
        else $error("byte position did not advance");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_out.valid && (o_out.out_last == $past(i_in.buffer_end))))
        else $error("result missing or out_last wrong after input transaction");

endmodule

// File: tb/tb_xorshift_keystream_byte_cipher.sv
`timescale 1ns / 100ps

module tb_xorshift_keystream_byte_cipher;

    typedef enum logic {
        ROW_BYTE,
        ROW_KEY
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        xkbc_pkg::t_word   key;
        xkbc_pkg::t_byte   data;
        logic              first;
        logic              last;
        logic              fixed;
        xkbc_pkg::t_byte   want;
    } t_stim_row;

    typedef struct packed {
        xkbc_pkg::t_byte out_byte;
        logic            out_last;
    } t_cipher_out;

    localparam int unsigned NUM_ITEMS = 1150;

    localparam t_stim_row DIRECTED_ROWS[23] = '{
        '{ROW_BYTE, 64'h0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF},
        '{ROW_BYTE, 64'h0, 8'hA5, 1'b1, 1'b0, 1'b1, 8'hA5},
        '{ROW_BYTE, 64'h0, 8'h5A, 1'b0, 1'b1, 1'b1, 8'h5A},
        '{ROW_KEY,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h3C, 1'b1, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_KEY,  64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h7F, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hFE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hAA, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h0F, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'hF0, 1'b0, 1'b1, 1'b0, 8'h00},
        '{ROW_KEY,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h11, 1'b0, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h22, 1'b0, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE, 64'h0, 8'h33, 1'b1, 1'b0, 1'b1, 8'h33},
        '{ROW_BYTE, 64'h0, 8'h44, 1'b0, 1'b1, 1'b1, 8'h44}
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_wr_en;
    xkbc_pkg::t_word cfg_wr_data;
    logic            row_fixed;
    xkbc_pkg::t_byte row_want;

    xkbc_in_if  in_ch();
    xkbc_out_if out_ch();

    xorshift_keystream_byte_cipher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    xkbc_pkg::t_word key_shadow = '0;
    xkbc_pkg::t_word stream_word = '0;
    xkbc_pkg::t_pos  stream_pos = '0;
    t_cipher_out     expected_bytes[$];
    int unsigned     fail_count = 0;
    int unsigned     items_sent = 0;
    int unsigned     src_idle_pct = 37;
    int unsigned     snk_idle_pct = 77;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic xkbc_pkg::t_word advance_word(input xkbc_pkg::t_word w);
        xkbc_pkg::t_word s;
        s = w ^ (w >> xkbc_pkg::SHIFT_A);
        s = s ^ (s << xkbc_pkg::SHIFT_B);
        s = s ^ (s >> xkbc_pkg::SHIFT_C);
        return s * xkbc_pkg::MUL_CONST;
    endfunction

    function automatic t_cipher_out encrypt_byte(input xkbc_pkg::t_byte d, input logic first,
                                                 input logic last);
        t_cipher_out r;
        if (first) begin
            stream_word = key_shadow;
            stream_pos  = '0;
        end
        if (stream_pos == '0) begin
            stream_word = advance_word(stream_word);
        end
        r.out_byte = d ^ stream_word[stream_pos * 8 +: 8];
        r.out_last = last;
        stream_pos = stream_pos + 3'd1;
        return r;
    endfunction

    function automatic xkbc_pkg::t_word pick_key();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_cipher_out exp_r;
        t_cipher_out got_r;
        if (i_rst_n) begin
            if (cfg_wr_en) begin
                key_shadow = cfg_wr_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                exp_r = encrypt_byte(in_ch.data_byte, in_ch.buffer_start, in_ch.buffer_end);
                if (row_fixed) begin
                    exp_r.out_byte = row_want;
                end
                expected_bytes.push_back(exp_r);
            end
            if (out_ch.valid && out_ch.ready) begin
                got_r = '{out_byte: out_ch.out_byte, out_last: out_ch.out_last};
                if (expected_bytes.size() == 0) begin
                    $error("Unexpected transaction: out_byte=%h out_last=%b",
                           got_r.out_byte, got_r.out_last);
                    fail_count++;
                end else begin
                    exp_r = expected_bytes.pop_front();
                    if (got_r.out_byte !== exp_r.out_byte) begin
                        $error("out_byte: expected %h, actual %h", exp_r.out_byte,
                               got_r.out_byte);
                        fail_count++;
                    end
                    if (got_r.out_last !== exp_r.out_last) begin
                        $error("out_last: expected %b, actual %b", exp_r.out_last,
                               got_r.out_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_byte(input xkbc_pkg::t_byte d, input logic first, input logic last,
                             input logic fixed, input xkbc_pkg::t_byte want);
        if (items_sent < 400) begin
            src_idle_pct = 37;
            snk_idle_pct = 77;
        end else if (items_sent < 800) begin
            src_idle_pct = 77;
            snk_idle_pct = 37;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= d;
        in_ch.buffer_start <= first;
        in_ch.buffer_end   <= last;
        row_fixed          <= fixed;
        row_want           <= want;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_key(input xkbc_pkg::t_word k);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        i_rst_n            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        row_fixed          <= 1'b0;
        row_want           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.buffer_start <= 1'b0;
        in_ch.buffer_end   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_KEY) begin
                load_key(DIRECTED_ROWS[i].key);
            end else begin
                send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].first,
                          DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].fixed,
                          DIRECTED_ROWS[i].want);
            end
        end

        while (items_sent < NUM_ITEMS) begin
            if ($urandom_range(7) == 0) begin
                load_key(pick_key());
            end
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'b0, '0);
                end
            end else begin
                len = ($urandom_range(15) == 0) ? $urandom_range(30, 64)
                                                : $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    if (i > 0 && $urandom_range(49) == 0) begin
                        load_key(pick_key());
                    end
                    send_byte(8'($urandom_range(255)), i == 0, i == len - 1, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
